[rtl/core/hsbp_pkg.sv]
// ----------------------------------------------------------------------------
// hsbp_pkg
// Shared types and constants for the Huffman string bit packer: request
// codes, register indexes, datapath widths and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package hsbp_pkg;

    // Field widths
    localparam int SYM_W  = 8;
    localparam int CODE_W = 24;
    localparam int LEN_W  = 5;
    localparam int BYTE_W = 8;

    // Bit accumulator: up to seven leftover bits plus two full code words
    localparam int ACC_W  = BYTE_W + 2 * CODE_W;
    localparam int FILL_W = $clog2(ACC_W);
    localparam int SH_W   = FILL_W + 1;

    // Request codes
    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_ENCODE = 1'b1;

    // Configuration register indexes
    localparam int  CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_APPEND_EN  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_APPEND_SYM = 1'd1;

    // Controller to datapath
    typedef struct packed {
        logic capture;    // latch end-of-string flag of an encode request
        logic rd_in;      // read table at the incoming symbol
        logic rd_append;  // read table at the append symbol
        logic load_wr;    // write table entry from the incoming request
        logic merge;      // merge read code into the accumulator
        logic emit;       // move one byte into the output register
    } ctl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic eos;        // current request ends its string
        logic app_en;     // append symbol enabled
        logic nf_full;    // after merge: at least one full byte
        logic nf_pending; // after merge: some bits held
        logic full;       // at least one full byte held
        logic pending;    // some bits held
        logic out_free;   // output register can take a byte
    } dp_stat_t;

endpackage

[rtl/core/hsbp_ctrl.sv]
// ----------------------------------------------------------------------------
// hsbp_ctrl
// Sequencer for the bit packer: accepts requests, steps the datapath
// through table read, code merge, optional append merge and byte emission.
// ----------------------------------------------------------------------------
module hsbp_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              req_type,
    input  hsbp_pkg::dp_stat_t stat,
    output hsbp_pkg::ctl_cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MERGE_SYM,
        S_MERGE_APP,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // Decode state into commands and next state
    always_comb
    begin
        in_ready   = (state_reg == S_IDLE);
        accept     = in_valid && in_ready;
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req_type == hsbp_pkg::REQ_ENCODE)
                    begin
                        cmd.rd_in   = 1'b1;
                        cmd.capture = 1'b1;
                        state_next  = S_MERGE_SYM;
                    end
                    else
                    begin
                        cmd.load_wr = 1'b1;
                    end
                end
            end
            S_MERGE_SYM:
            begin
                cmd.merge = 1'b1;
                if (stat.eos && stat.app_en)
                begin
                    cmd.rd_append = 1'b1;
                    state_next    = S_MERGE_APP;
                end
                else if (stat.nf_full || (stat.eos && stat.nf_pending))
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_MERGE_APP:
            begin
                cmd.merge = 1'b1;
                // string always ends here: any held bit must go out
                if (stat.nf_full || stat.nf_pending)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (stat.full || (stat.eos && stat.pending))
                begin
                    cmd.emit = stat.out_free;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/core/hsbp_datapath.sv]
// ----------------------------------------------------------------------------
// hsbp_datapath
// Code table memory, configuration registers, MSB-first bit accumulator
// and output byte register.
// ----------------------------------------------------------------------------
module hsbp_datapath
#(
    parameter int MAX_CODE_LEN = 24,
    parameter int NUM_SYMBOLS  = 256
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  hsbp_pkg::ctl_cmd_t                    cmd,
    output hsbp_pkg::dp_stat_t                    stat,
    input  logic [hsbp_pkg::SYM_W-1:0]            symbol,
    input  logic [hsbp_pkg::CODE_W-1:0]           code_bits,
    input  logic [hsbp_pkg::LEN_W-1:0]            code_length,
    input  logic                                  end_of_string,
    input  logic                                  cfg_valid,
    input  logic [hsbp_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [hsbp_pkg::SYM_W-1:0]            cfg_data,
    input  logic                                  out_ready,
    output logic                                  out_valid,
    output logic [hsbp_pkg::BYTE_W-1:0]           packed_byte,
    output logic                                  last_of_string
);

    localparam int IDX_W   = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
    localparam int LEN_CAP = (MAX_CODE_LEN < hsbp_pkg::CODE_W) ? MAX_CODE_LEN
                                                               : hsbp_pkg::CODE_W;
    localparam logic [hsbp_pkg::LEN_W-1:0] CAP_LEN = hsbp_pkg::LEN_W'(LEN_CAP);
    localparam logic [hsbp_pkg::SYM_W:0]   SYM_LIM = (hsbp_pkg::SYM_W + 1)'(NUM_SYMBOLS);

    // Code table
    logic [hsbp_pkg::CODE_W-1:0] code_mem [NUM_SYMBOLS];
    logic [hsbp_pkg::LEN_W-1:0]  len_mem  [NUM_SYMBOLS];
    logic [NUM_SYMBOLS-1:0]      valid_reg;

    logic [hsbp_pkg::CODE_W-1:0] rd_code_reg;
    logic [hsbp_pkg::LEN_W-1:0]  rd_len_reg;
    logic                        rd_ok_reg;
    logic                        rd_ok_next;

    // Configuration
    logic                        app_en_reg;
    logic [hsbp_pkg::SYM_W-1:0]  app_sym_reg;

    // Accumulator
    logic [hsbp_pkg::ACC_W-1:0]  acc_reg;
    logic [hsbp_pkg::ACC_W-1:0]  acc_next;
    logic [hsbp_pkg::FILL_W-1:0] fill_reg;
    logic [hsbp_pkg::FILL_W-1:0] fill_next;
    logic                        eos_reg;

    // Output register
    logic                        out_valid_reg;
    logic [hsbp_pkg::BYTE_W-1:0] byte_reg;
    logic                        last_reg;

    logic [hsbp_pkg::SYM_W-1:0]  rd_addr;
    logic [IDX_W-1:0]            rd_idx;
    logic                        rd_in_range;
    logic [IDX_W-1:0]            wr_idx;
    logic                        wr_in_range;
    logic [hsbp_pkg::LEN_W-1:0]  wr_len;
    logic [hsbp_pkg::LEN_W-1:0]  use_len;
    logic [hsbp_pkg::CODE_W-1:0] code_masked;
    logic [hsbp_pkg::SH_W-1:0]   shift_amt;
    logic [hsbp_pkg::ACC_W-1:0]  merged_acc;
    logic [hsbp_pkg::FILL_W-1:0] merged_fill;
    logic                        out_free;

    // Address decode for table read and write
    always_comb
    begin
        rd_addr     = cmd.rd_append ? app_sym_reg : symbol;
        rd_idx      = rd_addr[IDX_W-1:0];
        rd_in_range = ({1'b0, rd_addr} < SYM_LIM);
        wr_idx      = symbol[IDX_W-1:0];
        wr_in_range = ({1'b0, symbol} < SYM_LIM);
        wr_len      = (code_length > CAP_LEN) ? CAP_LEN : code_length;
        rd_ok_next  = rd_in_range && valid_reg[rd_idx];
    end

    // Write and read table storage
    always_ff @(posedge clk)
    begin
        if (cmd.load_wr && wr_in_range)
        begin
            code_mem[wr_idx] <= code_bits;
            len_mem[wr_idx]  <= wr_len;
        end
        if (cmd.rd_in || cmd.rd_append)
        begin
            rd_code_reg <= code_mem[rd_idx];
            rd_len_reg  <= len_mem[rd_idx];
        end
    end

    // Track written entries and read validity
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_wr && wr_in_range)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
            if (cmd.rd_in || cmd.rd_append)
            begin
                rd_ok_reg <= rd_ok_next;
            end
        end
    end

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            app_en_reg  <= 1'b0;
            app_sym_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                hsbp_pkg::REG_APPEND_EN:  app_en_reg  <= cfg_data[0];
                hsbp_pkg::REG_APPEND_SYM: app_sym_reg <= cfg_data;
                default:                  app_en_reg  <= app_en_reg;
            endcase
        end
    end

    // Align the read code just below the held bits
    always_comb
    begin
        use_len     = rd_ok_reg ? rd_len_reg : '0;
        code_masked = rd_code_reg & ~({hsbp_pkg::CODE_W{1'b1}} << use_len);
        shift_amt   = hsbp_pkg::SH_W'(hsbp_pkg::ACC_W) - hsbp_pkg::SH_W'(fill_reg)
                      - hsbp_pkg::SH_W'(use_len);
        merged_acc  = acc_reg | (hsbp_pkg::ACC_W'(code_masked) << shift_amt);
        merged_fill = fill_reg + hsbp_pkg::FILL_W'(use_len);
        out_free    = !out_valid_reg || out_ready;
    end

    // Advance the accumulator on merge or emit
    always_comb
    begin
        acc_next  = acc_reg;
        fill_next = fill_reg;
        if (cmd.merge)
        begin
            acc_next  = merged_acc;
            fill_next = merged_fill;
        end
        else if (cmd.emit)
        begin
            if (fill_reg >= hsbp_pkg::FILL_W'(hsbp_pkg::BYTE_W))
            begin
                acc_next  = acc_reg << hsbp_pkg::BYTE_W;
                fill_next = fill_reg - hsbp_pkg::FILL_W'(hsbp_pkg::BYTE_W);
            end
            else
            begin
                // flush the partial byte, zero padded
                acc_next  = '0;
                fill_next = '0;
            end
        end
    end

    // Hold accumulator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            fill_reg <= '0;
            eos_reg  <= 1'b0;
        end
        else
        begin
            acc_reg  <= acc_next;
            fill_reg <= fill_next;
            if (cmd.capture)
            begin
                eos_reg <= end_of_string;
            end
        end
    end

    // Load output register; drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            byte_reg <= acc_reg[hsbp_pkg::ACC_W-1 -: hsbp_pkg::BYTE_W];
            if (fill_reg >= hsbp_pkg::FILL_W'(hsbp_pkg::BYTE_W))
            begin
                last_reg <= eos_reg
                            && (fill_reg == hsbp_pkg::FILL_W'(hsbp_pkg::BYTE_W));
            end
            else
            begin
                last_reg <= 1'b1;
            end
        end
    end

    // Report status
    always_comb
    begin
        stat.eos        = eos_reg;
        stat.app_en     = app_en_reg;
        stat.nf_full    = (merged_fill >= hsbp_pkg::FILL_W'(hsbp_pkg::BYTE_W));
        stat.nf_pending = (merged_fill != '0);
        stat.full       = (fill_reg >= hsbp_pkg::FILL_W'(hsbp_pkg::BYTE_W));
        stat.pending    = (fill_reg != '0);
        stat.out_free   = out_free;
    end

    assign out_valid      = out_valid_reg;
    assign packed_byte    = byte_reg;
    assign last_of_string = last_reg;

endmodule

[rtl/core/huffman_string_bit_packer_top.sv]
// ----------------------------------------------------------------------------
// huffman_string_bit_packer_top
// Huffman encoder for byte strings: loads a code table, packs codes MSB
// first into bytes and flushes any partial final byte, zero padded, at each string end.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------------
//   in       | in_valid / in_ready  | req_type symbol code_bits
//            |                      | code_length end_of_string
//   out      | out_valid / out_ready| packed_byte last_of_string
//   cfg      | cfg_valid / cfg_ready| cfg_index cfg_data
//
// A load request writes its table entry in its accept cycle. An encode
// request steps through table read and code merge, an append merge when
// the append symbol is merged, then byte emission until it is idle again;
// a single table read port and the byte-wide output register set the steps.
// Reset clears the table valid bits, the bit accumulator and the config.
// A stalled output holds the sequencer in its emit step; no request is taken.
// ----------------------------------------------------------------------------
module huffman_string_bit_packer_top
#(
    parameter int MAX_CODE_LEN = 24,
    parameter int NUM_SYMBOLS  = 256
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           req_type,
    input  logic [hsbp_pkg::SYM_W-1:0]     symbol,
    input  logic [hsbp_pkg::CODE_W-1:0]    code_bits,
    input  logic [hsbp_pkg::LEN_W-1:0]     code_length,
    input  logic                           end_of_string,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [hsbp_pkg::BYTE_W-1:0]    packed_byte,
    output logic                           last_of_string,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [hsbp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hsbp_pkg::SYM_W-1:0]     cfg_data
);

    hsbp_pkg::ctl_cmd_t cmd;
    hsbp_pkg::dp_stat_t stat;

    // Config writes are always taken
    assign cfg_ready = 1'b1;

    hsbp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .req_type (req_type),
        .stat     (stat),
        .cmd      (cmd)
    );

    hsbp_datapath
    #(
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .NUM_SYMBOLS  (NUM_SYMBOLS)
    )
    u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .symbol         (symbol),
        .code_bits      (code_bits),
        .code_length    (code_length),
        .end_of_string  (end_of_string),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .packed_byte    (packed_byte),
        .last_of_string (last_of_string)
    );

`ifndef SYNTHESIS
    // A load request completes in its accept cycle
    a_load_single_cycle : assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (req_type == hsbp_pkg::REQ_LOAD) |=> in_ready)
        else $error("load request did not return to ready");

    // An encode request occupies the sequencer
    a_encode_busy : assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (req_type == hsbp_pkg::REQ_ENCODE) |=> !in_ready)
        else $error("ready high right after encode request");

    // Bytes are only produced while a request is in work
    a_emit_while_busy : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("output byte produced while idle");
`endif

endmodule
